### hdl/lpfr_pkg.sv
// Shared types and constants for the length-prefixed frame receiver.
package lpfr_pkg;

    localparam logic [7:0] START_BYTE = 8'h7E;
    localparam logic [7:0] SUM_TARGET = 8'hFF;

    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_LEN_HI = 2'd1,
        PH_LEN_LO = 2'd2,
        PH_DATA   = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        K_DATA     = 3'd0,
        K_GOOD     = 3'd1,
        K_BAD      = 3'd2,
        K_TIMEOUT  = 3'd3,
        K_LINE_ERR = 3'd4
    } kind_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
        logic [3:0] errs;     // bit0 overrun, bit1 break, bit2 parity, bit3 framing
    } in_item_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [7:0]  data_byte;
        logic        last;
        logic [15:0] frame_length;
        logic [3:0]  error_bits;
    } result_t;

endpackage

### hdl/lpfr_parser.sv
// Frame parser: phase, length and checksum state plus the per-item result logic.
module lpfr_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  lpfr_pkg::in_item_t item,
    output lpfr_pkg::result_t  result
);
    import lpfr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic [15:0] length_total_reg, length_total_next;
    logic [15:0] bytes_remaining_reg, bytes_remaining_next;
    logic [7:0]  running_sum_reg, running_sum_next;

    logic [7:0]  sum_with_byte;
    logic [15:0] flen;
    logic        is_start;

    assign sum_with_byte = running_sum_reg + item.rx_byte;
    assign flen          = (phase_reg == PH_DATA) ? length_total_reg : 16'd0;
    assign is_start      = (item.rx_byte == START_BYTE);

    // next state
    always_comb
    begin
        phase_next           = phase_reg;
        length_high_next     = length_high_reg;
        length_total_next    = length_total_reg;
        bytes_remaining_next = bytes_remaining_reg;
        running_sum_next     = running_sum_reg;
        if (item.req_type == REQ_TIMEOUT || item.errs != 4'd0)
        begin
            phase_next = PH_IDLE;
        end
        else if (is_start)
        begin
            if (phase_reg == PH_IDLE)
            begin
                phase_next           = PH_LEN_HI;
                length_high_next     = 8'd0;
                length_total_next    = 16'd0;
                bytes_remaining_next = 16'd0;
                running_sum_next     = 8'd0;
            end
        end
        else
        begin
            case (phase_reg)
                PH_LEN_HI:
                begin
                    length_high_next = item.rx_byte;
                    phase_next       = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    length_total_next    = {length_high_reg, item.rx_byte};
                    bytes_remaining_next = {length_high_reg, item.rx_byte};
                    running_sum_next     = 8'd0;
                    phase_next           = PH_DATA;
                end
                PH_DATA:
                begin
                    if (bytes_remaining_reg != 16'd0)
                    begin
                        bytes_remaining_next = bytes_remaining_reg - 16'd1;
                        running_sum_next     = sum_with_byte;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // result
    always_comb
    begin
        result              = '0;
        result.kind         = K_DATA;
        result.frame_length = flen;
        if (item.req_type == REQ_TIMEOUT)
        begin
            result.valid = (phase_reg != PH_IDLE);
            result.kind  = K_TIMEOUT;
        end
        else if (item.errs != 4'd0)
        begin
            result.valid      = 1'b1;
            result.kind       = K_LINE_ERR;
            result.error_bits = item.errs;
        end
        else if (!is_start && phase_reg == PH_DATA)
        begin
            result.valid = 1'b1;
            if (bytes_remaining_reg != 16'd0)
            begin
                result.kind      = K_DATA;
                result.data_byte = item.rx_byte;
                result.last      = (bytes_remaining_reg == 16'd1);
            end
            else
            begin
                result.kind = (sum_with_byte == SUM_TARGET) ? K_GOOD : K_BAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_IDLE;
            length_high_reg     <= 8'd0;
            length_total_reg    <= 16'd0;
            bytes_remaining_reg <= 16'd0;
            running_sum_reg     <= 8'd0;
        end
        else if (go)
        begin
            phase_reg           <= phase_next;
            length_high_reg     <= length_high_next;
            length_total_reg    <= length_total_next;
            bytes_remaining_reg <= bytes_remaining_next;
            running_sum_reg     <= running_sum_next;
        end
    end

endmodule

### hdl/length_prefixed_frame_receiver_top.sv
// With no output stall, an accepted input item goes through the input register, then the result register,
// where its result item sits on the outputs until it is taken.
// Throughput: one input item per cycle while in_stall is low; the input register and result register
// let a new item in while a finished result waits to be taken.
// Reset (rst_n, async, active low) empties both registers and returns the parser
// to the idle hunt for the start byte with length and sum state cleared.
module length_prefixed_frame_receiver_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  rx_byte,
    input  logic        overrun_err,
    input  logic        break_err,
    input  logic        parity_err,
    input  logic        framing_err,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  data_byte,
    output logic        last,
    output logic [15:0] frame_length,
    output logic [3:0]  error_bits
);
    import lpfr_pkg::*;

    logic     in_valid_reg;
    in_item_t item_reg;
    logic     out_valid_reg;
    result_t  result_reg;
    result_t  result;
    logic     advance;

    // the input stage moves on whenever the result register can take a result
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.req_type <= req_type;
            item_reg.rx_byte  <= rx_byte;
            item_reg.errs     <= {framing_err, parity_err, break_err, overrun_err};
        end
    end

    lpfr_parser u_parser
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (in_valid_reg && advance),
        .item   (item_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg && result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg && result.valid)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = result_reg.kind;
    assign data_byte    = result_reg.data_byte;
    assign last         = result_reg.last;
    assign frame_length = result_reg.frame_length;
    assign error_bits   = result_reg.error_bits;

`ifndef SYNTHESIS
    a_held_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> in_valid_reg && $stable(item_reg))
        else $error("stalled input item was lost or changed");
    a_last_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> kind == K_DATA)
        else $error("last set on a status result");
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != K_DATA |-> data_byte == 8'd0)
        else $error("data byte not zero on a status result");
    a_err_bits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((kind == K_LINE_ERR) == (error_bits != 4'd0)))
        else $error("error bits disagree with result kind");
`endif

endmodule

### tb/length_prefixed_frame_receiver_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the length-prefixed frame receiver: directed and random UART traffic.
module length_prefixed_frame_receiver_top_tb;
    import lpfr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic        last;
        logic [15:0] frame_length;
        logic [3:0]  error_bits;
    } frame_event_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = 1'b0;
    logic [7:0]  rx_byte = 8'h00;
    logic        overrun_err = 1'b0;
    logic        break_err = 1'b0;
    logic        parity_err = 1'b0;
    logic        framing_err = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic        last;
    logic [15:0] frame_length;
    logic [3:0]  error_bits;

    // parser state as the testbench sees it
    phase_t      rx_phase = PH_IDLE;
    logic [7:0]  len_hi = 8'h00;
    logic [15:0] len_total = 16'h0000;
    logic [15:0] bytes_left = 16'h0000;
    logic [7:0]  byte_sum = 8'h00;

    frame_event_t expected_events[$];
    int           sender_idle_pct = 0;
    int           receiver_stall_pct = 0;
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           traffic_items = 0;

    length_prefixed_frame_receiver_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .rx_byte      (rx_byte),
        .overrun_err  (overrun_err),
        .break_err    (break_err),
        .parity_err   (parity_err),
        .framing_err  (framing_err),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .last         (last),
        .frame_length (frame_length),
        .error_bits   (error_bits)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Advance the parser on one accepted item and queue the event it produces.
    function automatic void parse_rx_item(input logic rt, input logic [7:0] b,
                                          input logic [3:0] errs);
        frame_event_t ev;
        logic [7:0]   total;
        ev.kind         = K_DATA;
        ev.data_byte    = 8'h00;
        ev.last         = 1'b0;
        ev.frame_length = (rx_phase == PH_DATA) ? len_total : 16'h0000;
        ev.error_bits   = 4'h0;
        if (rt == REQ_TIMEOUT)
        begin
            if (rx_phase != PH_IDLE)
            begin
                rx_phase = PH_IDLE;
                ev.kind = K_TIMEOUT;
                expected_events.push_back(ev);
            end
        end
        else if (errs != 4'h0)
        begin
            rx_phase = PH_IDLE;
            ev.kind = K_LINE_ERR;
            ev.error_bits = errs;
            expected_events.push_back(ev);
        end
        else if (b == START_BYTE)
        begin
            // start byte anywhere but idle is dropped
            if (rx_phase == PH_IDLE)
            begin
                rx_phase   = PH_LEN_HI;
                len_hi     = 8'h00;
                len_total  = 16'h0000;
                bytes_left = 16'h0000;
                byte_sum   = 8'h00;
            end
        end
        else
        begin
            case (rx_phase)
                PH_LEN_HI:
                begin
                    len_hi = b;
                    rx_phase = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_total = {len_hi, b};
                    bytes_left = len_total;
                    byte_sum = 8'h00;
                    rx_phase = PH_DATA;
                end
                PH_DATA:
                begin
                    if (bytes_left != 16'h0000)
                    begin
                        bytes_left = bytes_left - 16'd1;
                        byte_sum = byte_sum + b;
                        ev.data_byte = b;
                        ev.last = (bytes_left == 16'h0000);
                    end
                    else
                    begin
                        total = byte_sum + b;
                        rx_phase = PH_IDLE;
                        ev.kind = (total == SUM_TARGET) ? K_GOOD : K_BAD;
                    end
                    expected_events.push_back(ev);
                end
                default:
                begin
                end
            endcase
        end
    endfunction

    task automatic send_item(input logic rt, input logic [7:0] b, input logic [3:0] errs);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= rt;
        rx_byte     <= b;
        overrun_err <= errs[0];
        break_err   <= errs[1];
        parity_err  <= errs[2];
        framing_err <= errs[3];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        parse_rx_item(rt, b, errs);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Well-formed frame with random content; rarely cut short by a timeout or line error.
    task automatic send_frame(input int n_data, input bit good);
        logic [7:0] b;
        logic [7:0] ck;
        logic [7:0] sum;
        int         i;
        sum = 8'h00;
        if (n_data[7:0] == START_BYTE)
            n_data = n_data + 1;
        if (rx_phase != PH_IDLE)
            send_item(REQ_TIMEOUT, 8'h00, 4'h0);
        send_item(REQ_BYTE, START_BYTE, 4'h0);
        send_item(REQ_BYTE, n_data[15:8], 4'h0);
        send_item(REQ_BYTE, n_data[7:0], 4'h0);
        traffic_items += 3;
        for (i = 0; i < n_data; i++)
        begin
            if ($urandom_range(0, 99) < 2)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_item(REQ_TIMEOUT, 8'($urandom_range(0, 255)), 4'h0);
                else
                    send_item(REQ_BYTE, 8'($urandom_range(0, 255)),
                              4'($urandom_range(1, 15)));
                traffic_items++;
                return;
            end
            b = 8'($urandom_range(0, 255));
            if (b == START_BYTE)
            begin
                // stray start byte inside the payload is dropped, frame carries on
                send_item(REQ_BYTE, START_BYTE, 4'h0);
                b = b ^ 8'h01;
            end
            send_item(REQ_BYTE, b, 4'h0);
            sum = sum + b;
            traffic_items++;
        end
        ck = SUM_TARGET - sum;
        if (!good || ck == START_BYTE)
        begin
            ck = ck + 8'($urandom_range(1, 255));
            while (ck == START_BYTE || ck == SUM_TARGET - sum)
                ck = ck + 8'd1;
        end
        send_item(REQ_BYTE, ck, 4'h0);
        traffic_items++;
    endtask

    task automatic test_directed_cases();
        send_item(REQ_TIMEOUT, 8'h00, 4'h0);     // timeout while idle: nothing
        send_item(REQ_BYTE, 8'h00, 4'h0);        // plain byte while idle: nothing
        send_item(REQ_BYTE, 8'hFF, 4'h1);        // line error while idle
        send_item(REQ_BYTE, START_BYTE, 4'h0);
        send_item(REQ_BYTE, 8'h00, 4'h0);
        send_item(REQ_BYTE, START_BYTE, 4'h0);   // dropped in length phase
        send_item(REQ_BYTE, 8'h02, 4'h0);
        send_item(REQ_BYTE, 8'hFF, 4'h0);
        send_item(REQ_BYTE, START_BYTE, 4'h0);   // dropped in data phase
        send_item(REQ_BYTE, 8'h01, 4'h0);
        send_item(REQ_BYTE, 8'hFF, 4'h0);        // good checksum
        // zero length, bad checksum
        send_item(REQ_BYTE, START_BYTE, 4'h0);
        send_item(REQ_BYTE, 8'h00, 4'h0);
        send_item(REQ_BYTE, 8'h00, 4'h0);
        send_item(REQ_BYTE, 8'h12, 4'h0);
        // maximum length, aborted by timeout after one data byte
        send_item(REQ_BYTE, START_BYTE, 4'h0);
        send_item(REQ_BYTE, 8'hFF, 4'h0);
        send_item(REQ_BYTE, 8'hFF, 4'h0);
        send_item(REQ_BYTE, 8'hAA, 4'h0);
        send_item(REQ_TIMEOUT, 8'h55, 4'h0);
        // line error during the length
        send_item(REQ_BYTE, START_BYTE, 4'h0);
        send_item(REQ_BYTE, 8'h00, 4'h0);
        send_item(REQ_BYTE, 8'h33, 4'hE);
        // zero length, good checksum
        send_item(REQ_BYTE, START_BYTE, 4'h0);
        send_item(REQ_BYTE, 8'h00, 4'h0);
        send_item(REQ_BYTE, 8'h00, 4'h0);
        send_item(REQ_BYTE, 8'hFF, 4'h0);
    endtask

    task automatic test_random_traffic(input int n_items);
        int pick;
        int n_data;
        int k;
        int start_items;
        int frames;
        int n_tail;
        start_items = traffic_items;
        frames = 0;
        while (traffic_items - start_items < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                k = $urandom_range(0, 99);
                if (k < 85)
                    n_data = $urandom_range(0, 8);
                else if (k < 97)
                    n_data = $urandom_range(9, 40);
                else
                    n_data = $urandom_range(200, 300);
                send_frame(n_data, $urandom_range(0, 99) < 70);
                frames++;
                if (frames % 25 == 0)
                    wait_drained();
            end
            else if (pick < 85)
            begin
                // truncated frame: start and a few bytes, left hanging
                n_tail = $urandom_range(0, 3);
                send_item(REQ_BYTE, START_BYTE, 4'h0);
                repeat (n_tail)
                    send_item(REQ_BYTE, 8'($urandom_range(0, 255)), 4'h0);
                traffic_items += 1 + n_tail;
            end
            else
            begin
                send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          ($urandom_range(0, 1) == 0) ? 4'h0 : 4'($urandom_range(1, 15)));
                traffic_items++;
            end
        end
    endtask

    task automatic test_drain_pause();
        send_frame(5, 1'b1);
        wait_drained();
        send_frame(3, 1'b0);
        wait_drained();
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        frame_event_t ev;
        cycle_count++;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_events.size() == 0)
            begin
                $error("unexpected result item: kind %0d data %0h", kind, data_byte);
                mismatch_count++;
            end
            else
            begin
                ev = expected_events.pop_front();
                if (kind !== ev.kind)
                begin
                    $error("kind: expected %0d, got %0d", ev.kind, kind);
                    mismatch_count++;
                end
                if (data_byte !== ev.data_byte)
                begin
                    $error("data_byte: expected %0h, got %0h", ev.data_byte, data_byte);
                    mismatch_count++;
                end
                if (last !== ev.last)
                begin
                    $error("last: expected %0d, got %0d", ev.last, last);
                    mismatch_count++;
                end
                if (frame_length !== ev.frame_length)
                begin
                    $error("frame_length: expected %0h, got %0h", ev.frame_length,
                           frame_length);
                    mismatch_count++;
                end
                if (error_bits !== ev.error_bits)
                begin
                    $error("error_bits: expected %0h, got %0h", ev.error_bits, error_bits);
                    mismatch_count++;
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("length_prefixed_frame_receiver_top_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 13;
        receiver_stall_pct = 65;
        test_directed_cases();
        test_random_traffic(150);

        sender_idle_pct = 65;
        receiver_stall_pct = 13;
        test_drain_pause();
        test_random_traffic(150);

        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        test_random_traffic(150);

        wait_drained();
        if (mismatch_count == 0)
            $display("length_prefixed_frame_receiver_top_tb: PASS");
        else
            $display("length_prefixed_frame_receiver_top_tb: FAIL");
        $finish;
    end

endmodule
